// ----- rtl/lss_pkg.sv -----
// Shared types and constants for the LIFO stack with search.
package lss_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int WORD_W    = 32;
	localparam int REQ_W     = 3;
	localparam int POS_W     = 5;
	localparam int CAP_W     = 6;
	localparam int FILL_W    = 6;
	localparam int ST_W      = 3;

	localparam logic [CAP_W-1:0] CAP_RST = 6'd32;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH   = 3'd0,
		REQ_POP    = 3'd1,
		REQ_PEEK   = 3'd2,
		REQ_SEARCH = 3'd3,
		REQ_UPDATE = 3'd4
	} req_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_RANGE    = 3'd4
	} status_t;

	typedef struct packed {
		logic                     push;
		logic                     pop;
		logic                     upd;
		logic signed [WORD_W-1:0] wdata;
		logic signed [WORD_W-1:0] key;
	} cell_ctrl_t;

endpackage

// ----- rtl/lifo_stack_with_search.sv -----
// Top level: bounded LIFO stack of signed words with search and in-place update.
//
// Requests arrive on the in channel (in_valid/in_ready) as req_type, value and
// position; each gives exactly one word on the out channel (out_valid/out_ready)
// with status, data, found_position, fill_count, is_empty and is_full.
// For push, pop, peek, update and unknown codes the result word is registered
// at the accepting edge and is offered in the next cycle.
// Search walks the stack, a row of DEPTH cells: the hit and its cell index
// travel down that row one cell per cycle, so the length of the row, and any
// out channel stall at the end, set the search latency. No request is taken meanwhile.
// A new request is taken while the result register is empty or being read, so
// requests other than search go back to back at one per cycle while out_ready is high.
// If the receiver stalls, the result word holds and in_ready drops.
// capacity is written through cfg_we/cfg_wdata, by the user only while idle;
// the block itself does not enforce this. Zero acts as one, values above DEPTH as DEPTH.
// Reset empties the stack, sets capacity to 32 and drops out_valid; entry
// contents are not cleared and are never read before being written.
module lifo_stack_with_search #(
	parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lss_pkg::CAP_W-1:0]          cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lss_pkg::REQ_W-1:0]          req_type,
	input  logic signed [lss_pkg::WORD_W-1:0]  value,
	input  logic [lss_pkg::POS_W-1:0]          position,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [lss_pkg::ST_W-1:0]           status,
	output logic signed [lss_pkg::WORD_W-1:0]  data,
	output logic [lss_pkg::POS_W-1:0]          found_position,
	output logic [lss_pkg::FILL_W-1:0]         fill_count,
	output logic                               is_empty,
	output logic                               is_full
);
	import lss_pkg::*;

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int WW0 = (CW > CAP_W) ? CW : CAP_W;
	localparam int WW  = (WW0 > POS_W) ? WW0 : POS_W;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SRCH = 2'b10
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            scan_q;
	logic [CAP_W-1:0]         cap_q;
	logic signed [WORD_W-1:0] key_q;

	logic                     out_valid_q;
	status_t                  status_q;
	logic signed [WORD_W-1:0] data_q;
	logic [POS_W-1:0]         fpos_q;
	logic [FILL_W-1:0]        fill_q;
	logic                     empty_q;
	logic                     full_q;

	logic signed [WORD_W-1:0] entry_w [DEPTH];
	logic signed [WORD_W-1:0] up_w    [DEPTH];
	logic signed [WORD_W-1:0] dn_w    [DEPTH];
	logic                     hit_w   [DEPTH];
	logic                     hin_w   [DEPTH];
	logic [AW-1:0]            idx_w   [DEPTH];
	logic [AW-1:0]            iin_w   [DEPTH];

	cell_ctrl_t               ctrl;
	logic [WW-1:0]            cap_eff;
	logic                     full_now;
	logic                     in_fire;
	logic                     out_free;
	logic                     srch_done;
	logic                     push_ok;
	logic                     pop_ok;
	logic                     upd_ok;
	logic                     go_srch;
	status_t                  st_nx;
	logic signed [WORD_W-1:0] data_nx;
	logic [CW-1:0]            cnt_nx;
	logic [AW-1:0]            upd_idx;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = WW'(1);
		end else if (WW'(cap_q) > WW'(DEPTH)) begin
			cap_eff = WW'(DEPTH);
		end else begin
			cap_eff = WW'(cap_q);
		end
	end

	assign full_now  = WW'(count_q) >= cap_eff;
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign in_fire   = in_valid && in_ready;
	assign srch_done = (state_q == S_SRCH) && (scan_q == CW'(DEPTH)) && out_free;
	assign upd_idx   = AW'(WW'(count_q) - WW'(position) - WW'(1));

	always_comb begin
		push_ok = 1'b0;
		pop_ok  = 1'b0;
		upd_ok  = 1'b0;
		go_srch = 1'b0;
		st_nx   = ST_OK;
		data_nx = '0;
		cnt_nx  = count_q;
		case (req_t'(req_type))
			REQ_PUSH: begin
				if (full_now) begin
					st_nx = ST_FULL;
				end else begin
					push_ok = 1'b1;
					cnt_nx  = count_q + CW'(1);
				end
			end
			REQ_POP: begin
				if (count_q == '0) begin
					st_nx = ST_EMPTY;
				end else begin
					pop_ok  = 1'b1;
					data_nx = entry_w[0];
					cnt_nx  = count_q - CW'(1);
				end
			end
			REQ_PEEK: begin
				if (count_q == '0) begin
					st_nx = ST_EMPTY;
				end else begin
					data_nx = entry_w[0];
				end
			end
			REQ_SEARCH: begin
				go_srch = 1'b1;
			end
			REQ_UPDATE: begin
				if (WW'(position) >= WW'(count_q)) begin
					st_nx = ST_RANGE;
				end else begin
					upd_ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ctrl.push  = in_fire && push_ok;
		ctrl.pop   = in_fire && pop_ok;
		ctrl.upd   = in_fire && upd_ok;
		ctrl.wdata = value;
		ctrl.key   = key_q;
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign up_w[gi]  = value;
				assign hin_w[gi] = 1'b0;
				assign iin_w[gi] = '0;
			end else begin : g_body
				assign up_w[gi]  = entry_w[gi-1];
				assign hin_w[gi] = hit_w[gi-1];
				assign iin_w[gi] = idx_w[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_tail
				assign dn_w[gi] = entry_w[gi];
			end else begin : g_mid
				assign dn_w[gi] = entry_w[gi+1];
			end

			lss_cell #(
				.DEPTH (DEPTH),
				.IDX   (gi)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.fill     (count_q),
				.upd_idx  (upd_idx),
				.up_entry (up_w[gi]),
				.dn_entry (dn_w[gi]),
				.hit_in   (hin_w[gi]),
				.idx_in   (iin_w[gi]),
				.entry    (entry_w[gi]),
				.hit_out  (hit_w[gi]),
				.idx_out  (idx_w[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			cap_q       <= CAP_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (in_fire) begin
				count_q <= cnt_nx;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire && go_srch) begin
						state_q <= S_SRCH;
						scan_q  <= '0;
					end
				end
				S_SRCH: begin
					if (scan_q != CW'(DEPTH)) begin
						scan_q <= scan_q + CW'(1);
					end
					if (srch_done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if ((in_fire && !go_srch) || srch_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the search key; load the result word
	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q <= value;
		end
		if (in_fire && !go_srch) begin
			status_q <= st_nx;
			data_q   <= data_nx;
			fpos_q   <= '0;
			fill_q   <= FILL_W'(cnt_nx);
			empty_q  <= (cnt_nx == '0);
			full_q   <= (WW'(cnt_nx) >= cap_eff);
		end else if (srch_done) begin
			status_q <= hit_w[DEPTH-1] ? ST_OK : ST_NOTFOUND;
			data_q   <= '0;
			fpos_q   <= hit_w[DEPTH-1] ?
				POS_W'(WW'(count_q) - WW'(idx_w[DEPTH-1]) - WW'(1)) : '0;
			fill_q   <= FILL_W'(count_q);
			empty_q  <= (count_q == '0);
			full_q   <= full_now;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign data           = data_q;
	assign found_position = fpos_q;
	assign fill_count     = fill_q;
	assign is_empty       = empty_q;
	assign is_full        = full_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(count_q) <= WW'(DEPTH))
		else $error("fill count beyond depth");

	a_no_take_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> !in_ready)
		else $error("request taken during search");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not grow the stack");

	a_search_result: assert property (@(posedge clk) disable iff (!arst_n)
		srch_done |=> out_valid_q && (status_q == ST_OK || status_q == ST_NOTFOUND))
		else $error("search finished without a result word");

endmodule

// ----- rtl/lss_cell.sv -----
// One stack cell: holds one word, shifts on push and pop, takes an update, forwards the search hit.
module lss_cell #(
	parameter int DEPTH = lss_pkg::DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lss_pkg::cell_ctrl_t                ctrl,
	input  logic [$clog2(DEPTH+1)-1:0]         fill,
	input  logic [$clog2(DEPTH)-1:0]           upd_idx,
	input  logic signed [lss_pkg::WORD_W-1:0]  up_entry,
	input  logic signed [lss_pkg::WORD_W-1:0]  dn_entry,
	input  logic                               hit_in,
	input  logic [$clog2(DEPTH)-1:0]           idx_in,
	output logic signed [lss_pkg::WORD_W-1:0]  entry,
	output logic                               hit_out,
	output logic [$clog2(DEPTH)-1:0]           idx_out
);
	import lss_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [WORD_W-1:0] entry_q;
	logic                     hit_q;
	logic [AW-1:0]            idx_q;
	logic                     match;

	assign match = (CW'(IDX) < fill) && (entry_q == ctrl.key);

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			entry_q <= up_entry;
		end else if (ctrl.pop) begin
			entry_q <= dn_entry;
		end else if (ctrl.upd && (upd_idx == AW'(IDX))) begin
			entry_q <= ctrl.wdata;
		end
	end

	// later cells sit lower in the stack, so a hit here overrides one from above
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			idx_q <= '0;
		end else begin
			hit_q <= match | hit_in;
			idx_q <= match ? AW'(IDX) : idx_in;
		end
	end

	assign entry   = entry_q;
	assign hit_out = hit_q;
	assign idx_out = idx_q;

endmodule
